// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the motor transaction design.
// Every macro samples on the rising edge of clk_i and stays quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define MCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define MCT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/mct_pkg.sv =====
// ---------------------------------------------------------------------------
// mct_pkg
// Types, constants and helper functions of the motor command transaction.
// ---------------------------------------------------------------------------
package mct_pkg;

  // Field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned ANGLE_W    = 19;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned MOTOR_ID_W = 4;
  localparam int unsigned TIMEOUT_W  = 16;

  // Stream widths
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 72;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd100;

  // Default tick counter width
  localparam int unsigned TICK_BITS_DEF = 16;

  // Frame geometry
  localparam int unsigned RX_LEN      = 10;
  localparam int unsigned RX_IDX_W    = $clog2(RX_LEN);
  localparam int unsigned FRAME_LEN   = 5;
  localparam int unsigned FRAME_CNT_W = $clog2(FRAME_LEN + 1);

  // Command bytes and CRC polynomial
  localparam logic [BYTE_W-1:0] CMD_ENABLE  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_DISABLE = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_ANGLE   = 8'h05;
  localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;

  // Angle conversion: two pi in unsigned Q3.16 and the scaled reciprocal
  localparam int unsigned      TWO_PI_INT   = 411775;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q16 = ANGLE_W'(TWO_PI_INT);
  localparam logic [RAW_W-1:0] ANGLE_FULL   = 16'hFFFF;
  localparam int unsigned      ANGLE_SHIFT  = 24;
  localparam int unsigned      RECIP_W      = 22;
  localparam int unsigned      PROD_W       = ANGLE_W + RECIP_W;
  localparam int unsigned      EST_W        = PROD_W - ANGLE_SHIFT;
  localparam int unsigned      NUM_W        = ANGLE_W + RAW_W + 1;
  localparam longint unsigned  RECIP_L      =
    ((64'd65535 << ANGLE_SHIFT) + 64'(TWO_PI_INT / 2)) / 64'(TWO_PI_INT);
  localparam logic [RECIP_W-1:0] ANGLE_RECIP = RECIP_W'(RECIP_L);
  localparam logic [PROD_W-1:0]  EST_ROUND   = PROD_W'(1) << (ANGLE_SHIFT - 1);
  localparam logic [NUM_W-1:0]   HALF_TWO_PI = NUM_W'(TWO_PI_INT / 2);

  // Saturation of the signed feedback words
  localparam logic [RAW_W-1:0] RAW_MOST_NEG = 16'h8000;
  localparam logic [RAW_W-1:0] RAW_SAT_NEG  = 16'h8001;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENABLE  = 3'd0,
    REQ_DISABLE = 3'd1,
    REQ_ANGLE   = 3'd2,
    REQ_TX_DONE = 3'd3,
    REQ_RX_BYTE = 3'd4,
    REQ_DMA_ERR = 3'd5,
    REQ_TICK    = 3'd6,
    REQ_CANCEL  = 3'd7
  } req_e;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BUSY        = 3'd1,
    ST_RANGE       = 3'd2,
    ST_TIMEOUT     = 3'd3,
    ST_DMA_ERR     = 3'd4,
    ST_ID_MISMATCH = 3'd5,
    ST_CRC_ERR     = 3'd6
  } status_e;

  // Registered input item, with the first angle estimate already formed
  typedef struct packed {
    req_e               req;
    logic [ANGLE_W-1:0] angle_q16;
    logic [BYTE_W-1:0]  rx_data;
    logic [EST_W-1:0]   angle_est;
  } item_t;

  // Feedback carried by a successful completion
  typedef struct packed {
    logic [RAW_W-1:0]        angle_raw;
    logic signed [RAW_W-1:0] speed_raw;
    logic signed [RAW_W-1:0] current_raw;
    logic                    motor_enabled;
    logic [BYTE_W-1:0]       motor_state;
  } fb_t;

  // Results of one item handed to the output stage
  typedef struct packed {
    logic                             load;
    kind_e                            kind;
    logic [FRAME_LEN-1:0][BYTE_W-1:0] frame;
    status_e                          status;
    fb_t                              fb;
  } res_t;

  // One byte of CRC8, MSB first, no reflection.
  function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int unsigned b = 0; b < BYTE_W; b++) begin
      c = {c[BYTE_W-2:0], 1'b0} ^ (c[BYTE_W-1] ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // Little-endian word with the most negative code pulled up by one.
  function automatic logic signed [RAW_W-1:0] sat_word(input logic [BYTE_W-1:0] lo,
                                                       input logic [BYTE_W-1:0] hi);
    logic [RAW_W-1:0] w;
    w = {hi, lo};
    if (w == RAW_MOST_NEG) begin
      w = RAW_SAT_NEG;
    end
    return $signed(w);
  endfunction

endpackage

// ===== design/mct_in_stage.sv =====
// ---------------------------------------------------------------------------
// mct_in_stage
// Input register of the transaction block. Takes one item from the stream
// and forms the first estimate of the scaled angle on the way in.
// ---------------------------------------------------------------------------
module mct_in_stage
  import mct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // angle_q16, rx_data
  input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type
  input  logic                 take_i,
  output logic                 valid_o,
  output item_t                item_o
);

  logic              valid_q;
  item_t             item_q;
  logic [PROD_W-1:0] prod;

  // The slot frees up in the same cycle that the core takes the item.
  assign s_axis_tready = !valid_q || take_i;

  // Angle times the reciprocal of two pi, rounded; within one of the result.
  assign prod = PROD_W'(s_axis_tdata[ANGLE_W-1:0]) * PROD_W'(ANGLE_RECIP) + EST_ROUND;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req       <= req_e'(s_axis_tuser);
      item_q.angle_q16 <= s_axis_tdata[ANGLE_W-1:0];
      item_q.rx_data   <= s_axis_tdata[ANGLE_W +: BYTE_W];
      item_q.angle_est <= prod[ANGLE_SHIFT +: EST_W];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/mct_core.sv =====
// ---------------------------------------------------------------------------
// mct_core
// Transaction state, configuration registers, frame build with CRC8, response
// collection and checking. One registered item per cycle while the output is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mct_core
  import mct_pkg::*;
#(
  parameter int unsigned TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  input  logic                  out_free_i,
  output logic                  take_o,
  output res_t                  res_o
);

  localparam int unsigned CMP_W = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // Positions of the response fields
  localparam int unsigned IDX_ID      = 0;
  localparam int unsigned IDX_STATE   = 1;
  localparam int unsigned IDX_CUR_LO  = 3;
  localparam int unsigned IDX_CUR_HI  = 4;
  localparam int unsigned IDX_SPD_LO  = 5;
  localparam int unsigned IDX_SPD_HI  = 6;
  localparam int unsigned IDX_ANG_LO  = 7;
  localparam int unsigned IDX_ANG_HI  = 8;
  localparam int unsigned IDX_CRC     = RX_LEN - 1;

  logic [MOTOR_ID_W-1:0] motor_id_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic                  active_q, active_d;
  logic                  tx_fin_q, tx_fin_d;
  logic [RX_IDX_W-1:0]   rx_cnt_q, rx_cnt_d;
  logic [BYTE_W-1:0]     rx_crc_q, rx_crc_d;
  logic [TICK_BITS-1:0]  elapsed_q, elapsed_d;
  logic [BYTE_W-1:0]     rx_buf_q [RX_LEN];

  logic                  rx_wr;
  logic                  go_idle;
  logic                  complete;
  logic [TICK_BITS-1:0]  tick_next;
  logic                  tick_expired;
  logic                  angle_over;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      est_mul;
  logic signed [NUM_W:0] rem;
  logic [EST_W-1:0]      raw_est;
  logic [RAW_W-1:0]      angle_val;
  logic [BYTE_W-1:0]     id_byte;
  logic [BYTE_W-1:0]     cmd_byte;
  logic [RAW_W-1:0]      value_word;
  logic [BYTE_W-1:0]     frame_crc;
  logic [BYTE_W-1:0]     crc_byte;

  assign take_o  = item_valid_i && out_free_i;
  assign id_byte = BYTE_W'(motor_id_q);

  // Angle correction: exact remainder of the estimate decides one step up or down.
  assign num     = (NUM_W'(item_i.angle_q16) << RAW_W) - NUM_W'(item_i.angle_q16)
                   + HALF_TWO_PI;
  assign est_mul = NUM_W'(item_i.angle_est) * NUM_W'(TWO_PI_Q16);
  assign rem     = $signed({1'b0, num}) - $signed({1'b0, est_mul});

  always_comb begin
    if (rem < 0) begin
      raw_est = item_i.angle_est - 1'b1;
    end else if (rem >= $signed({1'b0, NUM_W'(TWO_PI_Q16)})) begin
      raw_est = item_i.angle_est + 1'b1;
    end else begin
      raw_est = item_i.angle_est;
    end
  end

  assign angle_over = item_i.angle_q16 > TWO_PI_Q16;
  assign angle_val  = (item_i.angle_q16 == TWO_PI_Q16) ? ANGLE_FULL : raw_est[RAW_W-1:0];

  // Command frame and its CRC
  always_comb begin
    if (item_i.req == REQ_ENABLE) begin
      cmd_byte = CMD_ENABLE;
    end else if (item_i.req == REQ_DISABLE) begin
      cmd_byte = CMD_DISABLE;
    end else begin
      cmd_byte = CMD_ANGLE;
    end
  end

  assign value_word = (item_i.req == REQ_ANGLE) ? angle_val : '0;
  assign frame_crc  = crc8_next(crc8_next(crc8_next(crc8_next('0, id_byte), cmd_byte),
                                          value_word[BYTE_W-1:0]),
                                value_word[RAW_W-1:BYTE_W]);

  // Tick counter saturates at its all-ones value.
  assign tick_next    = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign tick_expired = (CMP_W'(tick_next) >= CMP_W'(timeout_q)) || (tick_next == TICK_MAX);

  // The tenth byte may arrive in this very cycle.
  assign crc_byte = rx_wr ? item_i.rx_data : rx_buf_q[IDX_CRC];

  // Next state and results
  always_comb begin
    active_d  = active_q;
    tx_fin_d  = tx_fin_q;
    rx_cnt_d  = rx_cnt_q;
    rx_crc_d  = rx_crc_q;
    elapsed_d = elapsed_q;
    rx_wr     = 1'b0;
    go_idle   = 1'b0;
    complete  = 1'b0;
    res_o     = '0;
    res_o.kind   = KIND_STATUS;
    res_o.status = ST_OK;

    if (take_o) begin
      unique case (item_i.req)
        REQ_ENABLE, REQ_DISABLE, REQ_ANGLE: begin
          res_o.load = 1'b1;
          if (item_i.req == REQ_ANGLE && angle_over) begin
            res_o.status = ST_RANGE;
          end else if (active_q) begin
            res_o.status = ST_BUSY;
          end else begin
            res_o.kind  = KIND_TX;
            res_o.frame = {frame_crc, value_word[RAW_W-1:BYTE_W],
                           value_word[BYTE_W-1:0], cmd_byte, id_byte};
            active_d    = 1'b1;
            tx_fin_d    = 1'b0;
            rx_cnt_d    = '0;
            rx_crc_d    = '0;
            elapsed_d   = '0;
          end
        end
        REQ_TX_DONE: begin
          if (active_q) begin
            tx_fin_d = 1'b1;
            complete = (rx_cnt_q == RX_IDX_W'(RX_LEN));
          end
        end
        REQ_RX_BYTE: begin
          if (active_q) begin
            if (rx_cnt_q < RX_IDX_W'(RX_LEN)) begin
              rx_wr    = 1'b1;
              rx_cnt_d = rx_cnt_q + 1'b1;
              if (rx_cnt_q < RX_IDX_W'(IDX_CRC)) begin
                rx_crc_d = crc8_next(rx_crc_q, item_i.rx_data);
              end
            end
            complete = tx_fin_q && (rx_cnt_d == RX_IDX_W'(RX_LEN));
          end
        end
        REQ_DMA_ERR: begin
          if (active_q) begin
            go_idle      = 1'b1;
            res_o.load   = 1'b1;
            res_o.status = ST_DMA_ERR;
          end
        end
        REQ_TICK: begin
          if (active_q) begin
            elapsed_d = tick_next;
            if (tick_expired) begin
              go_idle      = 1'b1;
              res_o.load   = 1'b1;
              res_o.status = ST_TIMEOUT;
            end
          end
        end
        REQ_CANCEL: begin
          go_idle      = 1'b1;
          res_o.load   = 1'b1;
          res_o.status = ST_OK;
        end
      endcase

      // Both sides done: check the response.
      if (complete) begin
        go_idle    = 1'b1;
        res_o.load = 1'b1;
        if (rx_buf_q[IDX_ID] != id_byte) begin
          res_o.status = ST_ID_MISMATCH;
        end else if (rx_crc_q != crc_byte) begin
          res_o.status = ST_CRC_ERR;
        end else begin
          res_o.status           = ST_OK;
          res_o.fb.motor_state   = rx_buf_q[IDX_STATE];
          res_o.fb.motor_enabled = rx_buf_q[IDX_STATE][0];
          res_o.fb.current_raw   = sat_word(rx_buf_q[IDX_CUR_LO], rx_buf_q[IDX_CUR_HI]);
          res_o.fb.speed_raw     = sat_word(rx_buf_q[IDX_SPD_LO], rx_buf_q[IDX_SPD_HI]);
          res_o.fb.angle_raw     = {rx_buf_q[IDX_ANG_HI], rx_buf_q[IDX_ANG_LO]};
        end
      end
    end

    if (go_idle) begin
      active_d  = 1'b0;
      tx_fin_d  = 1'b0;
      rx_cnt_d  = '0;
      elapsed_d = '0;
    end
  end

  // Transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      tx_fin_q  <= 1'b0;
      rx_cnt_q  <= '0;
      rx_crc_q  <= '0;
      elapsed_q <= '0;
    end else begin
      active_q  <= active_d;
      tx_fin_q  <= tx_fin_d;
      rx_cnt_q  <= rx_cnt_d;
      rx_crc_q  <= rx_crc_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q <= '0;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOTOR_ID: motor_id_q <= cfg_wdata_i[MOTOR_ID_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i[TIMEOUT_W-1:0];
      endcase
    end
  end

  // Response bytes, written at the current count
  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < RX_LEN; i++) begin
      if (rx_wr && (rx_cnt_q == RX_IDX_W'(i))) begin
        rx_buf_q[i] <= item_i.rx_data;
      end
    end
  end

  `MCT_ASSERT(a_rx_cnt_range, rx_cnt_q <= RX_IDX_W'(RX_LEN), "response count beyond frame length")
  `MCT_ASSERT(a_idle_clean, !active_q |-> (rx_cnt_q == '0) && !tx_fin_q && (elapsed_q == '0), "idle with stale transaction state")
  `MCT_ASSERT(a_frame_starts, take_o && res_o.load && (res_o.kind == KIND_TX) |=> active_q, "frame sent but transaction not active")

endmodule

// ===== design/mct_out_stage.sv =====
// ---------------------------------------------------------------------------
// mct_out_stage
// Result register. Holds a five-byte frame or one status result and hands
// the items out one per cycle on the master stream while the receiver is ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mct_out_stage
  import mct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  res_t                 res_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tx_data, status, motor_state, motor_enabled, current_raw, speed_raw, angle_raw
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,   // result_kind
  output logic                 m_axis_tlast    // last
);

  logic                             valid_q;
  logic [FRAME_CNT_W-1:0]           cnt_q;
  kind_e                            kind_q;
  logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_q;
  status_e                          status_q;
  fb_t                              fb_q;
  logic                             last;
  logic                             pop;

  assign last   = (kind_q == KIND_STATUS) || (cnt_q == FRAME_CNT_W'(1));
  assign pop    = valid_q && m_axis_tready;
  assign free_o = !valid_q || (pop && last);

  // Valid flag and remaining item count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (res_i.load) begin
      valid_q <= 1'b1;
      cnt_q   <= (res_i.kind == KIND_TX) ? FRAME_CNT_W'(FRAME_LEN) : FRAME_CNT_W'(1);
    end else if (pop) begin
      valid_q <= !last;
      cnt_q   <= cnt_q - 1'b1;
    end
  end

  // Payload; the frame shifts down one byte per item handed out.
  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      kind_q   <= res_i.kind;
      frame_q  <= res_i.frame;
      status_q <= res_i.status;
      fb_q     <= res_i.fb;
    end else if (pop) begin
      frame_q  <= frame_q >> BYTE_W;
    end
  end

  // Stream outputs
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = (kind_q == KIND_TX) ? M_TDATA_W'(frame_q[0]) :
                         {4'b0000, fb_q.angle_raw, fb_q.speed_raw, fb_q.current_raw,
                          fb_q.motor_enabled, fb_q.motor_state, status_q, 8'h00};

  `MCT_ASSERT(a_frame_cnt, valid_q && (kind_q == KIND_TX) |-> (cnt_q != '0) && (cnt_q <= FRAME_CNT_W'(FRAME_LEN)), "frame count out of range")
  `MCT_ASSERT(a_load_when_free, res_i.load |-> free_o, "result loaded over a pending one")
  `MCT_ASSERT(a_hold_to_last, valid_q && m_axis_tready && !last |=> valid_q, "frame dropped before its last byte")

endmodule

// ===== design/crc8_motor_command_transaction.sv =====
// An accepted item is held in the input register; the core writes its first result
// to the result register, which drives the output stream. Throughput: one item per
// cycle while the result register is free; a start command holds it until all five
// frame bytes are out. Reset (asynchronous, active low) makes the block idle,
// motor_id 0, timeout 100 ticks; no clearing pass is needed.
// ---------------------------------------------------------------------------
// crc8_motor_command_transaction
// Command/response engine for a serially addressed motor: frames commands
// with CRC8, collects the ten-byte response and reports status and feedback.
// ---------------------------------------------------------------------------
module crc8_motor_command_transaction
  import mct_pkg::*;
#(
  parameter int unsigned TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // angle_q16, rx_data
  input  logic [REQ_W-1:0]      s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tx_data, status, motor_state, motor_enabled, current_raw, speed_raw, angle_raw
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tuser,   // result_kind
  output logic                  m_axis_tlast    // last
);

  logic  item_valid;
  item_t item;
  logic  take;
  logic  out_free;
  res_t  res;

  mct_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (take),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  mct_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_o        (res)
  );

  mct_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sim/crc8_motor_command_transaction_chk.sv =====
// ---------------------------------------------------------------------------
// crc8_motor_command_transaction_chk
// Watches the configuration port and both streams of the motor transaction
// engine. It keeps its own copy of the transaction state, works out the
// results of every accepted item and compares each delivered result, field by
// field, with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module crc8_motor_command_transaction_chk
  import mct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,   // angle_q16, rx_data
  input  logic [REQ_W-1:0]      s_tuser_i,   // req_type
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // tx_data, status, motor_state, motor_enabled, current_raw, speed_raw, angle_raw
  input  logic [M_TDATA_W-1:0]  m_tdata_i,
  input  logic                  m_tuser_i,   // result_kind
  input  logic                  m_tlast_i,   // last
  output int unsigned           err_cnt_o,
  output int unsigned           pending_o
);

  localparam int unsigned TICK_MAX    = (32'd1 << TICK_BITS_DEF) - 1;

  typedef struct {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    status_e     status;
    logic [7:0]  state;
    logic        enabled;
    logic [15:0] current;
    logic [15:0] speed;
    logic [15:0] angle;
  } motor_result_t;

  // Shadow registers and transaction state
  logic [MOTOR_ID_W-1:0] id_reg;
  logic [TIMEOUT_W-1:0]  timeout_reg;
  logic                  link_busy;
  logic                  tx_sent;
  int unsigned           rx_cnt;
  int unsigned           ticks_seen;
  logic [7:0]            rx_buf [RX_LEN];

  motor_result_t expected_results[$];

  // CRC8 with polynomial 0x07, MSB first.
  function automatic logic [7:0] crc_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Radians in Q3.16 to 0..65535, rounding half up, exact in integers.
  function automatic logic [15:0] angle_to_code(logic [ANGLE_W-1:0] q);
    longint unsigned num;
    if (q == TWO_PI_Q16) begin
      return ANGLE_FULL;
    end
    num = 64'(q) * 64'd65535 + 64'(TWO_PI_INT / 2);
    return 16'(num / 64'(TWO_PI_INT));
  endfunction

  // Little-endian word; the most negative code is reported one higher.
  function automatic logic [15:0] fold_word(logic [7:0] lo, logic [7:0] hi);
    logic [15:0] w;
    w = {hi, lo};
    return (w == RAW_MOST_NEG) ? RAW_SAT_NEG : w;
  endfunction

  function automatic motor_result_t status_result(status_e st);
    motor_result_t r;
    r.kind    = KIND_STATUS;
    r.tx_byte = '0;
    r.last    = 1'b1;
    r.status  = st;
    r.state   = '0;
    r.enabled = 1'b0;
    r.current = '0;
    r.speed   = '0;
    r.angle   = '0;
    return r;
  endfunction

  task automatic end_link();
    link_busy  = 1'b0;
    tx_sent    = 1'b0;
    rx_cnt     = 0;
    ticks_seen = 0;
  endtask

  // A start while busy only reports busy; otherwise the five-byte frame goes out.
  task automatic queue_frame(logic [7:0] cmd, logic [15:0] value);
    logic [7:0]    frame_bytes [FRAME_LEN];
    logic [7:0]    crc;
    motor_result_t r;
    if (link_busy) begin
      expected_results.push_back(status_result(ST_BUSY));
      return;
    end
    frame_bytes[0] = 8'(id_reg);
    frame_bytes[1] = cmd;
    frame_bytes[2] = value[7:0];
    frame_bytes[3] = value[15:8];
    crc = '0;
    for (int i = 0; i < 4; i++) begin
      crc = crc_update(crc, frame_bytes[i]);
    end
    frame_bytes[4] = crc;
    for (int i = 0; i < FRAME_LEN; i++) begin
      r         = status_result(ST_OK);
      r.kind    = KIND_TX;
      r.tx_byte = frame_bytes[i];
      r.last    = (i == FRAME_LEN - 1);
      expected_results.push_back(r);
    end
    end_link();
    link_busy = 1'b1;
  endtask

  // Completion once the frame is sent and all ten response bytes are in.
  task automatic try_finish();
    motor_result_t r;
    logic [7:0]    crc;
    if (!tx_sent || rx_cnt < RX_LEN) begin
      return;
    end
    end_link();
    if (rx_buf[0] != 8'(id_reg)) begin
      r = status_result(ST_ID_MISMATCH);
    end else begin
      crc = '0;
      for (int i = 0; i < RX_LEN - 1; i++) begin
        crc = crc_update(crc, rx_buf[i]);
      end
      if (crc != rx_buf[RX_LEN-1]) begin
        r = status_result(ST_CRC_ERR);
      end else begin
        r         = status_result(ST_OK);
        r.state   = rx_buf[1];
        r.enabled = rx_buf[1][0];
        r.current = fold_word(rx_buf[3], rx_buf[4]);
        r.speed   = fold_word(rx_buf[5], rx_buf[6]);
        r.angle   = {rx_buf[8], rx_buf[7]};
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic predict_item(req_e req, logic [ANGLE_W-1:0] q, logic [7:0] rxd);
    case (req)
      REQ_ENABLE: begin
        queue_frame(CMD_ENABLE, '0);
      end
      REQ_DISABLE: begin
        queue_frame(CMD_DISABLE, '0);
      end
      REQ_ANGLE: begin
        // The range check comes before the busy check.
        if (q > TWO_PI_Q16) begin
          expected_results.push_back(status_result(ST_RANGE));
        end else begin
          queue_frame(CMD_ANGLE, angle_to_code(q));
        end
      end
      REQ_TX_DONE: begin
        if (link_busy) begin
          tx_sent = 1'b1;
          try_finish();
        end
      end
      REQ_RX_BYTE: begin
        // Bytes beyond the tenth are dropped.
        if (link_busy) begin
          if (rx_cnt < RX_LEN) begin
            rx_buf[rx_cnt] = rxd;
            rx_cnt++;
          end
          try_finish();
        end
      end
      REQ_DMA_ERR: begin
        if (link_busy) begin
          end_link();
          expected_results.push_back(status_result(ST_DMA_ERR));
        end
      end
      REQ_TICK: begin
        if (link_busy) begin
          if (ticks_seen < TICK_MAX) begin
            ticks_seen++;
          end
          if (ticks_seen >= timeout_reg || ticks_seen >= TICK_MAX) begin
            end_link();
            expected_results.push_back(status_result(ST_TIMEOUT));
          end
        end
      end
      REQ_CANCEL: begin
        // Cancel always answers ok, idle or not.
        end_link();
        expected_results.push_back(status_result(ST_OK));
      end
    endcase
  endtask

  task automatic report(string what, logic [15:0] want, logic [15:0] got);
    err_cnt_o++;
    $display("%0t: mismatch in %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic compare_result(motor_result_t want, motor_result_t got);
    if (want.kind != got.kind) report("result kind", 16'(want.kind), 16'(got.kind));
    if (want.tx_byte != got.tx_byte) report("tx byte", 16'(want.tx_byte), 16'(got.tx_byte));
    if (want.last != got.last) report("last flag", 16'(want.last), 16'(got.last));
    if (want.status != got.status) report("status", 16'(want.status), 16'(got.status));
    if (want.state != got.state) report("motor state", 16'(want.state), 16'(got.state));
    if (want.enabled != got.enabled) report("enabled", 16'(want.enabled), 16'(got.enabled));
    if (want.current != got.current) report("current", want.current, got.current);
    if (want.speed != got.speed) report("speed", want.speed, got.speed);
    if (want.angle != got.angle) report("angle", want.angle, got.angle);
  endtask

  // Configuration shadow, prediction of accepted items, then the result check.
  always @(posedge clk_i or negedge rst_ni) begin
    motor_result_t seen;
    if (!rst_ni) begin
      id_reg      = '0;
      timeout_reg = TIMEOUT_RST;
      err_cnt_o   = 0;
      end_link();
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MOTOR_ID) begin
          id_reg = cfg_wdata_i[MOTOR_ID_W-1:0];
        end else begin
          timeout_reg = cfg_wdata_i[TIMEOUT_W-1:0];
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_item(req_e'(s_tuser_i), s_tdata_i[ANGLE_W-1:0], s_tdata_i[ANGLE_W +: 8]);
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.kind    = kind_e'(m_tuser_i);
        seen.tx_byte = m_tdata_i[7:0];
        seen.last    = m_tlast_i;
        seen.status  = status_e'(m_tdata_i[10:8]);
        seen.state   = m_tdata_i[18:11];
        seen.enabled = m_tdata_i[19];
        seen.current = m_tdata_i[35:20];
        seen.speed   = m_tdata_i[51:36];
        seen.angle   = m_tdata_i[67:52];
        if (expected_results.size() == 0) begin
          report("result with nothing outstanding", '0, {8'h00, m_tdata_i[7:0]});
        end else begin
          compare_result(expected_results.pop_front(), seen);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== sim/crc8_motor_command_transaction_tb.sv =====
// ---------------------------------------------------------------------------
// crc8_motor_command_transaction_tb
// Drives commands and response events into the motor transaction engine: a
// short directed opening, then phases of random transactions under several
// motor ids and timeouts, with random gaps on both streams. The checker beside
// the block predicts and compares; this module only makes stimulus and judges.
// ---------------------------------------------------------------------------
module crc8_motor_command_transaction_tb;
  import mct_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 256;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           items_sent   = 0;
  int unsigned           idle_cycles  = 0;
  int unsigned           ready_hold   = 0;
  logic                  back_to_back = 1'b0;
  logic [MOTOR_ID_W-1:0] cur_id       = '0;
  logic [TIMEOUT_W-1:0]  cur_timeout  = TIMEOUT_RST;
  logic [7:0]            reply [RX_LEN];

  crc8_motor_command_transaction u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  crc8_motor_command_transaction_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .err_cnt_o   (mismatches),
    .pending_o   (outstanding)
  );

  // Clock, period 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver back-pressure: short and long ready stretches, short stalls and a few long ones.
  always @(posedge clk_i) begin
    int unsigned r;
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(0, 12);
      end else if (r < 55) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(40, 120);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either stream for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (back_to_back) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and returns at the edge that accepts it, or after the gap that follows.
  task automatic put_item(req_e req, logic [ANGLE_W-1:0] q, logic [7:0] d);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({d, q});
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    items_sent++;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Same, with random content in the fields the request does not use.
  task automatic put_event(req_e req);
    put_item(req, ANGLE_W'($urandom), 8'($urandom));
  endtask

  // Waits until every outstanding result has been delivered and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Cancel any transaction, drain, then load a new id and timeout.
  task automatic apply_setting(logic [MOTOR_ID_W-1:0] id, logic [TIMEOUT_W-1:0] tmo);
    put_event(REQ_CANCEL);
    settle();
    write_reg(CFG_MOTOR_ID, CFG_DATA_W'(id));
    write_reg(CFG_TIMEOUT, tmo);
    cur_id      = id;
    cur_timeout = tmo;
  endtask

  task automatic seal_reply();
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < RX_LEN - 1; i++) begin
      crc = crc8_next(crc, reply[i]);
    end
    reply[RX_LEN-1] = crc;
  endtask

  // One start command followed by its response, with tx done placed at random
  // and the odd tick, abort or stray start mixed in.
  task automatic run_exchange();
    int unsigned        r;
    int unsigned        tx_pos;
    int unsigned        tick_pct;
    logic [ANGLE_W-1:0] q;
    back_to_back = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < RX_LEN; i++) begin
      reply[i] = 8'($urandom);
    end
    reply[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(cur_id);
    r = $urandom_range(0, 5);
    if (r == 0) begin
      reply[3] = 8'h00;
      reply[4] = 8'h80;
    end else if (r == 1) begin
      reply[5] = 8'h00;
      reply[6] = 8'h80;
    end
    seal_reply();
    if ($urandom_range(0, 7) == 0) begin
      reply[RX_LEN-1] ^= 8'($urandom_range(1, 255));
    end

    r = $urandom_range(0, 9);
    if (r < 3) begin
      put_event(REQ_ENABLE);
    end else if (r < 5) begin
      put_event(REQ_DISABLE);
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        q = TWO_PI_Q16;
      end else if (r == 1) begin
        q = ANGLE_W'($urandom_range(TWO_PI_INT + 1, (1 << ANGLE_W) - 1));
      end else if (r == 2) begin
        q = ANGLE_W'($urandom_range(0, 3));
      end else begin
        q = ANGLE_W'($urandom_range(0, TWO_PI_INT));
      end
      put_item(REQ_ANGLE, q, 8'($urandom));
    end

    tick_pct = (cur_timeout <= 20) ? 15 : 4;
    tx_pos = $urandom_range(0, RX_LEN);
    for (int i = 0; i < RX_LEN; i++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        put_event(REQ_TICK);
      end else if (r < tick_pct + 2) begin
        put_event(req_e'($urandom_range(REQ_ENABLE, REQ_ANGLE)));
      end else if (r < tick_pct + 3) begin
        put_event(REQ_DMA_ERR);
      end else if (r < tick_pct + 4) begin
        put_event(REQ_CANCEL);
      end
      if (i == tx_pos) begin
        put_event(REQ_TX_DONE);
      end
      put_item(REQ_RX_BYTE, ANGLE_W'($urandom), reply[i]);
    end
    // Surplus bytes are only possible while the frame is still going out.
    if (tx_pos == RX_LEN) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) put_event(REQ_RX_BYTE);
      end
      put_event(REQ_TX_DONE);
    end
    back_to_back = 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [MOTOR_ID_W-1:0] ids [PHASES];
    logic [TIMEOUT_W-1:0]  timeouts [PHASES];
    int unsigned           stop_at;

    ids      = '{4'd15, 4'd7, 4'd0, MOTOR_ID_W'($urandom), 4'd10, 4'd3};
    timeouts = '{16'd1, 16'd5, 16'hFFFF, TIMEOUT_W'($urandom_range(2, 30)), 16'd12, 16'd1000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with the reset values of id and timeout.
    // Events while idle are ignored.
    put_event(REQ_TICK);
    put_event(REQ_TX_DONE);
    put_item(REQ_RX_BYTE, '0, 8'hFF);
    put_event(REQ_DMA_ERR);
    // Start, a second start while busy, an out-of-range angle, then cancel.
    put_event(REQ_ENABLE);
    put_event(REQ_DISABLE);
    put_item(REQ_ANGLE, '1, 8'h00);
    put_event(REQ_CANCEL);
    // Angle of exactly two pi, aborted by a DMA error.
    put_item(REQ_ANGLE, TWO_PI_Q16, 8'h00);
    put_event(REQ_DMA_ERR);
    // Zero angle, then a clean response carrying the saturated current word.
    put_item(REQ_ANGLE, '0, 8'h00);
    put_event(REQ_TX_DONE);
    reply = '{8'h00, 8'h03, 8'hA5, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h34, 8'h12, 8'h00};
    seal_reply();
    for (int i = 0; i < RX_LEN; i++) begin
      put_item(REQ_RX_BYTE, '1, reply[i]);
    end

    // Random phases, one per id/timeout setting.
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(ids[p], timeouts[p]);
      stop_at = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 5) == 0) begin
          put_item(req_e'($urandom_range(0, 7)), ANGLE_W'($urandom), 8'($urandom));
        end else begin
          run_exchange();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
